// File: design/ibc_pkg.sv
// Package for the IMU bias calibrator: widths, command codes, sequencer states
// and the saturation helpers of the shared adder.
// No dependencies.
`timescale 1ns / 1ps

package ibc_pkg;

  localparam int AXES        = 6;
  localparam int RAW_W       = 16;
  localparam int RAWX_W      = 17;
  localparam int SUM_W       = 22;
  localparam int ALU_W       = 24;
  localparam int CNT_W       = 6;
  localparam int ONE_G_W     = 15;
  localparam int REM_W       = 6;
  localparam int AXIS_IDX_W  = 3;
  localparam int DIV_STEPS   = SUM_W;
  localparam int STEP_W      = 5;

  localparam int ONE_G_RESET     = 1366;
  localparam int MAX_SAMPLES_DEF = 63;
  localparam int CNT_MAX         = (1 << CNT_W) - 1;

  typedef enum logic [1:0] {
    CMD_CALIBRATE = 2'd0,
    CMD_FINISH    = 2'd1,
    CMD_CORRECT   = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_t;

  // Axis order: gyro x, y, z, accel x, y, z.
  localparam logic [AXIS_IDX_W-1:0] AXIS_GYRO_Y  = 3'd1;
  localparam logic [AXIS_IDX_W-1:0] AXIS_ACCEL_Y = 3'd4;
  localparam logic [AXIS_IDX_W-1:0] AXIS_LAST    = 3'd5;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ACCUM = 7'b0000010,
    S_DLOAD = 7'b0000100,
    S_DSTEP = 7'b0001000,
    S_DSIGN = 7'b0010000,
    S_CORR  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  typedef logic signed [ALU_W-1:0] alu_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [RAWX_W-1:0] rawx_t;

  localparam alu_t SUM_MAX_A = alu_t'((1 << (SUM_W - 1)) - 1);
  localparam alu_t SUM_MIN_A = -alu_t'(1 << (SUM_W - 1));
  localparam alu_t RAW_MAX_A = alu_t'((1 << (RAW_W - 1)) - 1);
  localparam alu_t RAW_MIN_A = -alu_t'(1 << (RAW_W - 1));

  function automatic sum_t sat_sum(alu_t v);
    sum_t res;
    if (v > SUM_MAX_A) begin
      res = SUM_MAX_A[SUM_W-1:0];
    end else if (v < SUM_MIN_A) begin
      res = SUM_MIN_A[SUM_W-1:0];
    end else begin
      res = v[SUM_W-1:0];
    end
    return res;
  endfunction

  function automatic raw_t sat_raw(alu_t v);
    raw_t res;
    if (v > RAW_MAX_A) begin
      res = RAW_MAX_A[RAW_W-1:0];
    end else if (v < RAW_MIN_A) begin
      res = RAW_MIN_A[RAW_W-1:0];
    end else begin
      res = v[RAW_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: design/imu_bias_calibrator.sv
// IMU bias calibrator: accumulates calibration samples, averages them into six
// biases and removes the biases from later samples.
// Depends on ibc_pkg.
//
// Usage: an input transaction carries a command and six raw signed axes.
// Calibrate adds the sample (accel z less one_g_counts) into saturating sums,
// up to the sample limit; further samples are dropped. Finish divides each sum
// by the sample count, stores and reports the biases and clears the sums; with
// no samples it reports the old biases and a count of zero. Correct subtracts
// the biases, negates the y axes and reports the saturated result. Command 3
// is dropped. The user must write one_g_counts over the cfg channel only while
// the block is idle; the block does not enforce it. All datapath arithmetic but
// the gravity subtraction at capture goes through one 24-bit adder. Calibrate
// and correct run one step per axis; finish per axis one magnitude step, 22
// divide steps and one sign step. The result is registered as the sequencer
// goes idle. in_ready is high only while the sequencer idles. A new item is
// accepted while a result waits; a finished result waits until the previous
// one is taken.
// Reset (synchronous) clears sums, count and biases and sets one_g_counts to 1366.
`timescale 1ns / 1ps

module imu_bias_calibrator #(
  parameter int MAX_SAMPLES = ibc_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_one_g_counts,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic signed [15:0] in_gyro_x,
  input  logic signed [15:0] in_gyro_y,
  input  logic signed [15:0] in_gyro_z,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_bias_report,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z,
  output logic [5:0]  out_sample_count
);

  localparam int SampleLimit = (MAX_SAMPLES > ibc_pkg::CNT_MAX) ? ibc_pkg::CNT_MAX
                                                                : MAX_SAMPLES;
  localparam logic [ibc_pkg::CNT_W-1:0] LimitCount = SampleLimit[ibc_pkg::CNT_W-1:0];
  localparam logic [ibc_pkg::STEP_W-1:0] LastStep =
    ibc_pkg::STEP_W'(ibc_pkg::DIV_STEPS - 1);

  ibc_pkg::state_t state_r, state_nxt;

  logic [ibc_pkg::ONE_G_W-1:0]    one_g_r;
  ibc_pkg::sum_t                  sums_r   [ibc_pkg::AXES];
  ibc_pkg::raw_t                  biases_r [ibc_pkg::AXES];
  ibc_pkg::rawx_t                 raw_r    [ibc_pkg::AXES];
  ibc_pkg::raw_t                  corr_r   [ibc_pkg::AXES];
  logic [ibc_pkg::CNT_W-1:0]      count_r;
  logic [ibc_pkg::AXIS_IDX_W-1:0] idx_r;
  logic [ibc_pkg::STEP_W-1:0]     step_r;
  logic [ibc_pkg::SUM_W-1:0]      quo_r;
  logic [ibc_pkg::REM_W-1:0]      rem_r;
  logic                           neg_r;
  logic                           rpt_bias_r;
  logic [ibc_pkg::CNT_W-1:0]      rpt_count_r;

  logic                           out_valid_r;
  logic                           out_bias_r;
  ibc_pkg::raw_t                  out_axis_r [ibc_pkg::AXES];
  logic [ibc_pkg::CNT_W-1:0]      out_count_r;

  logic                           in_fire;
  logic                           out_load;
  ibc_pkg::cmd_t                  cmd;
  ibc_pkg::sum_t                  sum_sel;
  ibc_pkg::rawx_t                 raw_sel;
  ibc_pkg::raw_t                  bias_sel;
  logic [ibc_pkg::REM_W:0]        rem_shift;
  logic                           div_ge;
  logic                           y_axis;

  ibc_pkg::alu_t                  alu_a, alu_b, alu_sum;
  logic                           alu_cin;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ibc_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cmd       = ibc_pkg::cmd_t'(in_command);
  assign out_load  = (state_r == ibc_pkg::S_EMIT) && (!out_valid_r || out_ready);

  assign sum_sel   = sums_r[idx_r];
  assign raw_sel   = raw_r[idx_r];
  assign bias_sel  = biases_r[idx_r];
  assign rem_shift = {rem_r, quo_r[ibc_pkg::SUM_W-1]};
  assign y_axis    = (idx_r == ibc_pkg::AXIS_GYRO_Y) || (idx_r == ibc_pkg::AXIS_ACCEL_Y);

  // The shared datapath adder of the block; operands are chosen by the sequencer state.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state_r)
      ibc_pkg::S_ACCUM: begin
        alu_a = ibc_pkg::alu_t'(sum_sel);
        alu_b = ibc_pkg::alu_t'(raw_sel);
      end
      ibc_pkg::S_DLOAD: begin
        alu_b   = ~ibc_pkg::alu_t'(sum_sel);
        alu_cin = 1'b1;
      end
      ibc_pkg::S_DSTEP: begin
        alu_a   = ibc_pkg::alu_t'({1'b0, rem_shift});
        alu_b   = ~ibc_pkg::alu_t'({1'b0, count_r});
        alu_cin = 1'b1;
      end
      ibc_pkg::S_DSIGN: begin
        if (neg_r) begin
          alu_b   = ~ibc_pkg::alu_t'({1'b0, quo_r});
          alu_cin = 1'b1;
        end else begin
          alu_a = ibc_pkg::alu_t'({1'b0, quo_r});
        end
      end
      ibc_pkg::S_CORR: begin
        // The y axes are negated, so they compute bias minus sample.
        if (y_axis) begin
          alu_a = ibc_pkg::alu_t'(bias_sel);
          alu_b = ~ibc_pkg::alu_t'(raw_sel);
        end else begin
          alu_a = ibc_pkg::alu_t'(raw_sel);
          alu_b = ~ibc_pkg::alu_t'(bias_sel);
        end
        alu_cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign alu_sum = alu_a + alu_b + ibc_pkg::alu_t'(alu_cin);
  assign div_ge  = !alu_sum[ibc_pkg::ALU_W-1];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ibc_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            ibc_pkg::CMD_CALIBRATE: begin
              if (count_r < LimitCount) begin
                state_nxt = ibc_pkg::S_ACCUM;
              end
            end
            ibc_pkg::CMD_FINISH: begin
              state_nxt = (count_r == '0) ? ibc_pkg::S_EMIT : ibc_pkg::S_DLOAD;
            end
            ibc_pkg::CMD_CORRECT: state_nxt = ibc_pkg::S_CORR;
            default: state_nxt = ibc_pkg::S_IDLE;
          endcase
        end
      end
      ibc_pkg::S_ACCUM: begin
        if (idx_r == ibc_pkg::AXIS_LAST) begin
          state_nxt = ibc_pkg::S_IDLE;
        end
      end
      ibc_pkg::S_DLOAD: state_nxt = ibc_pkg::S_DSTEP;
      ibc_pkg::S_DSTEP: begin
        if (step_r == LastStep) begin
          state_nxt = ibc_pkg::S_DSIGN;
        end
      end
      ibc_pkg::S_DSIGN: begin
        state_nxt = (idx_r == ibc_pkg::AXIS_LAST) ? ibc_pkg::S_EMIT : ibc_pkg::S_DLOAD;
      end
      ibc_pkg::S_CORR: begin
        if (idx_r == ibc_pkg::AXIS_LAST) begin
          state_nxt = ibc_pkg::S_EMIT;
        end
      end
      ibc_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = ibc_pkg::S_IDLE;
        end
      end
      default: state_nxt = ibc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ibc_pkg::S_IDLE;
      one_g_r     <= ibc_pkg::ONE_G_W'(ibc_pkg::ONE_G_RESET);
      count_r     <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ibc_pkg::AXES; i++) begin
        sums_r[i]   <= '0;
        biases_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        one_g_r <= cfg_one_g_counts;
      end

      unique case (state_r)
        ibc_pkg::S_IDLE: begin
          idx_r <= '0;
        end
        ibc_pkg::S_ACCUM: begin
          sums_r[idx_r] <= ibc_pkg::sat_sum(alu_sum);
          idx_r         <= idx_r + 1'b1;
          if (idx_r == ibc_pkg::AXIS_LAST) begin
            count_r <= count_r + 1'b1;
          end
        end
        ibc_pkg::S_DLOAD: begin
          step_r <= '0;
        end
        ibc_pkg::S_DSTEP: begin
          step_r <= step_r + 1'b1;
        end
        ibc_pkg::S_DSIGN: begin
          biases_r[idx_r] <= ibc_pkg::sat_raw(alu_sum);
          idx_r           <= idx_r + 1'b1;
          if (idx_r == ibc_pkg::AXIS_LAST) begin
            count_r <= '0;
            for (int i = 0; i < ibc_pkg::AXES; i++) begin
              sums_r[i] <= '0;
            end
          end
        end
        ibc_pkg::S_CORR: begin
          idx_r <= idx_r + 1'b1;
        end
        ibc_pkg::S_EMIT: begin
        end
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rpt_bias_r  <= (cmd == ibc_pkg::CMD_FINISH);
      rpt_count_r <= count_r;
      raw_r[0]    <= ibc_pkg::rawx_t'(in_gyro_x);
      raw_r[1]    <= ibc_pkg::rawx_t'(in_gyro_y);
      raw_r[2]    <= ibc_pkg::rawx_t'(in_gyro_z);
      raw_r[3]    <= ibc_pkg::rawx_t'(in_accel_x);
      raw_r[4]    <= ibc_pkg::rawx_t'(in_accel_y);
      // Calibration removes gravity from accel z once, at capture.
      if (cmd == ibc_pkg::CMD_CALIBRATE) begin
        raw_r[5] <= ibc_pkg::rawx_t'(in_accel_z)
                    - ibc_pkg::rawx_t'({2'b00, one_g_r});
      end else begin
        raw_r[5] <= ibc_pkg::rawx_t'(in_accel_z);
      end
    end

    if (state_r == ibc_pkg::S_DLOAD) begin
      neg_r <= sum_sel[ibc_pkg::SUM_W-1];
      quo_r <= sum_sel[ibc_pkg::SUM_W-1] ? alu_sum[ibc_pkg::SUM_W-1:0]
                                         : sum_sel[ibc_pkg::SUM_W-1:0];
      rem_r <= '0;
    end else if (state_r == ibc_pkg::S_DSTEP) begin
      // Restoring division: one quotient bit per cycle.
      rem_r <= div_ge ? alu_sum[ibc_pkg::REM_W-1:0] : rem_shift[ibc_pkg::REM_W-1:0];
      quo_r <= {quo_r[ibc_pkg::SUM_W-2:0], div_ge};
    end

    if (state_r == ibc_pkg::S_CORR) begin
      corr_r[idx_r] <= ibc_pkg::sat_raw(alu_sum);
    end

    if (out_load) begin
      out_bias_r  <= rpt_bias_r;
      out_count_r <= rpt_bias_r ? rpt_count_r : '0;
      for (int i = 0; i < ibc_pkg::AXES; i++) begin
        out_axis_r[i] <= rpt_bias_r ? biases_r[i] : corr_r[i];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_bias_report = out_bias_r;
  assign out_gyro_x         = out_axis_r[0];
  assign out_gyro_y         = out_axis_r[1];
  assign out_gyro_z         = out_axis_r[2];
  assign out_accel_x        = out_axis_r[3];
  assign out_accel_y        = out_axis_r[4];
  assign out_accel_z        = out_axis_r[5];
  assign out_sample_count   = out_count_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LimitCount)
    else $error("sample count above the limit");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ibc_pkg::S_DSTEP) |-> (count_r != '0))
    else $error("divide step with a zero sample count");

  a_corr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bias_r) |-> (out_count_r == '0))
    else $error("corrected sample carries a nonzero count");

  a_correct_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == ibc_pkg::CMD_CORRECT) |=> (state_r == ibc_pkg::S_CORR))
    else $error("correct transaction did not start correction");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ibc_pkg::S_DSIGN && idx_r == ibc_pkg::AXIS_LAST) |=>
      (count_r == '0 && state_r == ibc_pkg::S_EMIT))
    else $error("finish did not clear the sample count");

endmodule
